// File: hw/rtl/annexb_start_code_nal_splitter_macros.svh
// Assertion macros used by the start code splitter RTL (included by anxb_scan).
// Macros assume clock clk and active-low reset rst_n in the including module.
`ifndef ANNEXB_START_CODE_NAL_SPLITTER_MACROS_SVH
`define ANNEXB_START_CODE_NAL_SPLITTER_MACROS_SVH

// Same-cycle implication.
`define ANXB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ANXB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/anxb_pkg.sv
// Package for the Annex B start code splitter: widths, codes and shared types.
// No dependencies.
package anxb_pkg;

  localparam int MAX_FRAME_BYTES_LOG2 = 24;
  localparam int POS_W  = MAX_FRAME_BYTES_LOG2 + 1;
  localparam int SUM_W  = POS_W + 1;
  localparam int AGG_W  = 17;
  localparam int LIM_W  = 16;
  localparam int HDR_W  = 2;
  localparam int PFX_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [PFX_W-1:0] PFX_SHORT = 3'd3;
  localparam logic [PFX_W-1:0] PFX_LONG  = 3'd4;
  localparam logic [PFX_W-1:0] PFX_NONE  = 3'd0;
  localparam logic [1:0] AGG_LEN_BYTES = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_SCAN   = 2'd2;

  localparam logic [LIM_W-1:0] RST_PAYLOAD_LIMIT = 16'd1443;
  localparam logic [HDR_W-1:0] RST_HEADER_BYTES  = 2'd2;

  typedef struct packed {
    logic [LIM_W-1:0] payload_limit;
    logic [HDR_W-1:0] payload_header_bytes;
    logic             bypass_scan;
  } cfg_t;

  typedef struct packed {
    logic             none_found;
    logic             can_aggregate;
    logic             final_unit;
    logic             fits_aggregate;
    logic [PFX_W-1:0] prefix_bytes;
    logic [POS_W-1:0] unit_size;
    logic [POS_W-1:0] unit_offset;
  } res_t;

endpackage

// File: hw/rtl/annexb_start_code_nal_splitter.sv
// Pipeline: a byte beat taken on the input is held in the input register, scanned and
// registered into the result stage once the result register is free or being taken;
// its result is then on out_*. Throughput: one byte per cycle while out_tready is high.
// The result register frees in the cycle it is taken.
// Reset (rst_n, synchronous): clears both stages, the frame state, and loads the
// register defaults (limit 1443, header 2, bypass off).
module annexb_start_code_nal_splitter
  import anxb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // end_of_frame
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [24:0] unit_offset, [49:25] unit_size, [52:50] prefix_bytes,
  // [53] fits_aggregate, [54] can_aggregate, [55] zero
  output logic [55:0]          out_tdata,
  output logic                 out_tlast,  // final_unit
  output logic                 out_tuser,  // none_found
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [LIM_W-1:0]     cfg_wdata
);

  cfg_t       cfg_r;
  logic       in_v_r;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       out_v_r;
  res_t       out_res_r;
  logic       adv;
  logic       has_res;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload_limit        <= RST_PAYLOAD_LIMIT;
      cfg_r.payload_header_bytes <= RST_HEADER_BYTES;
      cfg_r.bypass_scan          <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PAYLOAD_LIMIT: cfg_r.payload_limit        <= cfg_wdata;
        CFG_HEADER_BYTES:  cfg_r.payload_header_bytes <= cfg_wdata[HDR_W-1:0];
        CFG_BYPASS_SCAN:   cfg_r.bypass_scan          <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  anxb_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .data_byte    (in_data_r),
    .end_of_frame (in_last_r),
    .cfg          (cfg_r),
    .has_res      (has_res),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && has_res) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_res_r.can_aggregate, out_res_r.fits_aggregate,
                       out_res_r.prefix_bytes, out_res_r.unit_size, out_res_r.unit_offset};
  assign out_tlast  = out_res_r.final_unit;
  assign out_tuser  = out_res_r.none_found;

endmodule

// File: hw/rtl/anxb_scan.sv
// Per-byte start code scanner: frame state, unit bookkeeping and aggregation budget.
// Depends on anxb_pkg and the splitter assertion macros.
`include "annexb_start_code_nal_splitter_macros.svh"

module anxb_scan
  import anxb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       end_of_frame,
  input  cfg_t       cfg,
  output logic       has_res,
  output res_t       res
);

  logic [1:0]       zero_run_r, zero_run_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             unit_open_r, unit_open_nxt;
  logic [POS_W-1:0] open_off_r, open_off_nxt;
  logic [PFX_W-1:0] open_pfx_r, open_pfx_nxt;
  logic [AGG_W-1:0] agg_total_r, agg_total_nxt;
  logic [1:0]       agg_cnt_r, agg_cnt_nxt;

  logic             pos_ok, sc_hit, try_close, try_fin, fits_raw, do_agg;
  logic [POS_W-1:0] pos_inc, span, close_size, fin_size, agg_size;
  logic [PFX_W-1:0] new_pfx;
  logic [LIM_W-1:0] budget;
  logic [SUM_W-1:0] agg_sum;
  logic             frame_idle, pfx_legal, agg_legal;

  assign pos_ok  = !pos_r[POS_W-1];
  assign pos_inc = pos_r + POS_W'(1);
  assign pos_nxt = pos_ok ? pos_inc : pos_r;

  assign sc_hit = pos_ok && !cfg.bypass_scan && (data_byte == START_BYTE) &&
                  (zero_run_r >= 2'd2) && !end_of_frame;
  assign new_pfx = (zero_run_r == 2'd3) ? PFX_LONG : PFX_SHORT;

  assign span       = pos_inc - open_off_r;
  assign close_size = (span > POS_W'(new_pfx)) ? span - POS_W'(new_pfx) : '0;
  assign fin_size   = (pos_nxt > open_off_r) ? pos_nxt - open_off_r : '0;
  assign agg_size   = end_of_frame ? fin_size : close_size;

  assign budget  = (cfg.payload_limit > LIM_W'(cfg.payload_header_bytes)) ?
                   cfg.payload_limit - LIM_W'(cfg.payload_header_bytes) : '0;
  assign agg_sum = SUM_W'(agg_total_r) + SUM_W'(agg_size) + SUM_W'(AGG_LEN_BYTES);
  assign fits_raw = (agg_sum <= SUM_W'(budget));

  assign try_close = sc_hit && unit_open_r;
  assign try_fin   = end_of_frame && !cfg.bypass_scan && unit_open_r;
  assign do_agg    = (try_close || try_fin) && fits_raw;

  assign agg_total_nxt = end_of_frame ? '0 : (do_agg ? agg_sum[AGG_W-1:0] : agg_total_r);

  always_comb begin
    agg_cnt_nxt = agg_cnt_r;
    if (do_agg && (agg_cnt_r < 2'd2)) begin
      agg_cnt_nxt = agg_cnt_r + 2'd1;
    end
  end

  // result selection
  always_comb begin
    has_res = 1'b0;
    res     = '0;
    if (end_of_frame) begin
      has_res = 1'b1;
      res.final_unit = 1'b1;
      priority if (cfg.bypass_scan) begin
        res.unit_size = pos_nxt;
      end else if (unit_open_r) begin
        res.unit_offset    = open_off_r;
        res.unit_size      = fin_size;
        res.prefix_bytes   = open_pfx_r;
        res.fits_aggregate = do_agg;
        res.can_aggregate  = (agg_cnt_nxt >= 2'd2);
      end else begin
        res.none_found = 1'b1;
      end
    end else if (try_close) begin
      has_res = 1'b1;
      res.unit_offset    = open_off_r;
      res.unit_size      = close_size;
      res.prefix_bytes   = open_pfx_r;
      res.fits_aggregate = do_agg;
    end
  end

  // scan state
  always_comb begin
    zero_run_nxt  = zero_run_r;
    unit_open_nxt = unit_open_r;
    open_off_nxt  = open_off_r;
    open_pfx_nxt  = open_pfx_r;
    if (pos_ok) begin
      priority if (cfg.bypass_scan) begin
        zero_run_nxt = 2'd0;
      end else if (data_byte == ZERO_BYTE) begin
        zero_run_nxt = (zero_run_r == 2'd3) ? zero_run_r : zero_run_r + 2'd1;
      end else if (sc_hit) begin
        zero_run_nxt  = 2'd0;
        unit_open_nxt = 1'b1;
        open_off_nxt  = pos_inc;
        open_pfx_nxt  = new_pfx;
      end else begin
        zero_run_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r  <= '0;
      pos_r       <= '0;
      unit_open_r <= 1'b0;
      open_off_r  <= '0;
      open_pfx_r  <= '0;
      agg_total_r <= '0;
      agg_cnt_r   <= '0;
    end else if (step) begin
      agg_total_r <= agg_total_nxt;
      if (end_of_frame) begin
        zero_run_r  <= '0;
        pos_r       <= '0;
        unit_open_r <= 1'b0;
        open_off_r  <= '0;
        open_pfx_r  <= '0;
        agg_cnt_r   <= '0;
      end else begin
        zero_run_r  <= zero_run_nxt;
        pos_r       <= pos_nxt;
        unit_open_r <= unit_open_nxt;
        open_off_r  <= open_off_nxt;
        open_pfx_r  <= open_pfx_nxt;
        agg_cnt_r   <= agg_cnt_nxt;
      end
    end
  end

  assign frame_idle = (pos_r == '0) && !unit_open_r && (agg_cnt_r == 2'd0);
  assign pfx_legal  = (open_pfx_r == PFX_SHORT) || (open_pfx_r == PFX_LONG);
  assign agg_legal  = (agg_total_r[AGG_W-1] == 1'b0) && (agg_cnt_r != 2'd3);

  `ANXB_ASSERT_NXT(a_eof_clears, step && end_of_frame, frame_idle, "frame state not cleared")
  `ANXB_ASSERT_IMP(a_open_pfx, unit_open_r, pfx_legal, "open unit has bad prefix length")
  `ANXB_ASSERT_IMP(a_agg_in_budget, 1'b1, agg_legal, "aggregate state out of range")
  `ANXB_ASSERT_IMP(a_close_needs_open, has_res && !res.final_unit, try_close, "close without open")

endmodule

// File: test/annexb_start_code_nal_splitter_tb.sv
// Self-checking testbench for annexb_start_code_nal_splitter: byte frames in, NAL unit
// descriptors out, checked against a cycle-free predictor kept in a scoreboard class.
// Depends on anxb_pkg and the splitter RTL only.
module annexb_start_code_nal_splitter_tb
  import anxb_pkg::*;
();

  localparam int IDLE_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] FRAME_CAP = 25'd1 << MAX_FRAME_BYTES_LOG2;

  class nal_unit_tracker;
    res_t expected_units[$];
    int   mismatch_count;
    int   units_checked;

    logic [LIM_W-1:0] limit;
    logic [HDR_W-1:0] hdr_bytes;
    logic             bypass;

    logic [1:0]       zero_run;
    logic [POS_W-1:0] byte_pos;
    logic             unit_open;
    logic [POS_W-1:0] open_off;
    logic [PFX_W-1:0] open_pfx;
    int unsigned      agg_total;
    int unsigned      agg_count;

    function new();
      limit     = RST_PAYLOAD_LIMIT;
      hdr_bytes = RST_HEADER_BYTES;
      bypass    = 1'b0;
      mismatch_count = 0;
      units_checked  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      zero_run  = '0;
      byte_pos  = '0;
      unit_open = 1'b0;
      open_off  = '0;
      open_pfx  = PFX_NONE;
      agg_total = 0;
      agg_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] val);
      case (idx)
        CFG_PAYLOAD_LIMIT: limit = val;
        CFG_HEADER_BYTES:  hdr_bytes = val[HDR_W-1:0];
        CFG_BYPASS_SCAN:   bypass = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_units.size();
    endfunction

    // Adds the unit to the aggregation budget when it still fits.
    function logic take_budget(logic [POS_W-1:0] sz);
      longint unsigned budget;
      budget = (limit > hdr_bytes) ? longint'(limit) - longint'(hdr_bytes) : 0;
      if (longint'(agg_total) + longint'(sz) + longint'(AGG_LEN_BYTES) <= budget) begin
        agg_total = agg_total + sz + AGG_LEN_BYTES;
        if (agg_count < 2) agg_count++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void emit(logic [POS_W-1:0] off, logic [POS_W-1:0] sz, logic [PFX_W-1:0] pfx,
                       logic fits, logic fin, logic can, logic none);
      res_t r;
      r = '0;
      r.unit_offset    = off;
      r.unit_size      = sz;
      r.prefix_bytes   = pfx;
      r.fits_aggregate = fits;
      r.final_unit     = fin;
      r.can_aggregate  = can;
      r.none_found     = none;
      expected_units = {expected_units, r};
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [POS_W-1:0] pos, noff, span, sz;
      logic [PFX_W-1:0] pfx;
      logic             fits;
      if (byte_pos < FRAME_CAP) begin
        pos = byte_pos;
        byte_pos = pos + 1'b1;
        if (bypass) begin
          zero_run = '0;
        end else if (b == ZERO_BYTE) begin
          if (zero_run < 2'd3) zero_run++;
        end else if (b == START_BYTE && zero_run >= 2'd2 && !last) begin
          pfx = (zero_run == 2'd3) ? PFX_LONG : PFX_SHORT;
          noff = pos + 1'b1;
          zero_run = '0;
          if (unit_open) begin
            span = noff - open_off;
            sz = (span > pfx) ? span - pfx : '0;
            fits = take_budget(sz);
            emit(open_off, sz, open_pfx, fits, 1'b0, 1'b0, 1'b0);
          end
          unit_open = 1'b1;
          open_off  = noff;
          open_pfx  = pfx;
        end else begin
          zero_run = '0;
        end
      end
      if (last) begin
        if (bypass) begin
          emit('0, byte_pos, PFX_NONE, 1'b0, 1'b1, 1'b0, 1'b0);
        end else if (unit_open) begin
          sz = (byte_pos > open_off) ? byte_pos - open_off : '0;
          fits = take_budget(sz);
          emit(open_off, sz, open_pfx, fits, 1'b1, agg_count >= 2, 1'b0);
        end else begin
          emit('0, '0, PFX_NONE, 1'b0, 1'b1, 1'b0, 1'b1);
        end
        clear_frame();
      end
    endfunction

    task report(string what);
      $display("ERROR: unit %0d: %s", units_checked, what);
      mismatch_count++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task match_unit(res_t got);
      res_t want;
      if (expected_units.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = expected_units[0];
        expected_units.delete(0);
        check_field("unit_offset", 32'(got.unit_offset), 32'(want.unit_offset));
        check_field("unit_size", 32'(got.unit_size), 32'(want.unit_size));
        check_field("prefix_bytes", 32'(got.prefix_bytes), 32'(want.prefix_bytes));
        check_field("fits_aggregate", 32'(got.fits_aggregate), 32'(want.fits_aggregate));
        check_field("final_unit", 32'(got.final_unit), 32'(want.final_unit));
        check_field("can_aggregate", 32'(got.can_aggregate), 32'(want.can_aggregate));
        check_field("none_found", 32'(got.none_found), 32'(want.none_found));
      end
      units_checked++;
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h00;   // [7:0] data_byte
  logic                 in_tlast = 1'b0;    // end_of_frame
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [24:0] unit_offset, [49:25] unit_size, [52:50] prefix_bytes,
  // [53] fits_aggregate, [54] can_aggregate, [55] zero
  logic [55:0]          out_tdata;
  logic                 out_tlast;          // final_unit
  logic                 out_tuser;          // none_found
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [LIM_W-1:0]     cfg_wdata = '0;

  nal_unit_tracker units;
  logic [7:0] frame_buf[$];
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   out_hold = 0;
  int   idle_cycles = 0;
  int   bytes_taken = 0;
  int   frames_sent = 0;
  int   settings_used = 1;

  annexb_start_code_nal_splitter dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  always #10 clk = ~clk;

  initial units = new();

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      units.take_byte(in_tdata, in_tlast);
      bytes_taken++;
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst_n) begin
      out_hold = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '0;
        got.unit_offset    = out_tdata[24:0];
        got.unit_size      = out_tdata[49:25];
        got.prefix_bytes   = out_tdata[52:50];
        got.fits_aggregate = out_tdata[53];
        got.can_aggregate  = out_tdata[54];
        got.final_unit     = out_tlast;
        got.none_found     = out_tuser;
        units.match_unit(got);
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        out_hold = out_calm ? 0 : $urandom_range(0, 12);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_tready <= (out_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // Drains every expected unit, then lets the pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (units.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    units.set_reg(idx, val);
  endtask

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ZERO_BYTE;
      4, 5:       return START_BYTE;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_start(bit long_code);
    if (long_code) frame_buf = {frame_buf, ZERO_BYTE};
    frame_buf = {frame_buf, ZERO_BYTE};
    frame_buf = {frame_buf, ZERO_BYTE};
    frame_buf = {frame_buf, START_BYTE};
  endfunction

  function automatic void build_frame();
    int nunits, len;
    frame_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) frame_buf = {frame_buf, noisy_byte()};
    end else begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) frame_buf = {frame_buf, noisy_byte()};
      nunits = $urandom_range(1, 4);
      repeat (nunits) begin
        push_start(1'($urandom_range(0, 1)));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 10);
        repeat (len)
          frame_buf = {frame_buf, ($urandom_range(0, 7) == 0) ? noisy_byte()
                                                              : 8'($urandom_range(0, 255))};
      end
      if ($urandom_range(0, 5) == 0) push_start(1'b0);
    end
  endfunction

  task automatic run_phase(input logic [LIM_W-1:0] lim, input logic [LIM_W-1:0] hdr,
                           input logic [LIM_W-1:0] byp, input int target);
    int start_bytes;
    drain();
    write_reg(CFG_PAYLOAD_LIMIT, lim);
    write_reg(CFG_HEADER_BYTES, hdr);
    write_reg(CFG_BYPASS_SCAN, byp);
    cfg_we <= 1'b0;
    settings_used++;
    start_bytes = bytes_taken;
    while (bytes_taken - start_bytes < target) begin
      build_frame();
      send_frame();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no start code; two zeros followed by a non-start byte
    frame_buf = '{8'h00, 8'h00, 8'h02, 8'hFF};
    send_frame();
    // short then long prefix, start code completing on the final byte
    frame_buf = '{8'h00, 8'h00, 8'h01, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h01,
                  8'hBB, 8'h00, 8'h00, 8'h01};
    send_frame();
    // leading garbage, saturated zero run
    frame_buf = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_frame();
    // empty unit between back-to-back start codes
    frame_buf = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h55};
    send_frame();

    drain();
    write_reg(CFG_UNUSED, 16'hFFFF);
    cfg_we <= 1'b0;
    units.set_reg(CFG_UNUSED, 16'hFFFF);

    run_phase(16'hFFFF, 16'd2, 16'd0, 90);
    run_phase(16'd3, 16'd1, 16'd0, 80);
    run_phase(16'd24, 16'd1, 16'd0, 90);
    run_phase(16'd1, 16'd2, 16'd0, 50);     // header above limit
    run_phase(16'd40, 16'd2, 16'd1, 60);    // bypass
    run_phase(16'($urandom_range(3, 80)), 16'($urandom_range(1, 2)), 16'd0, 90);
    run_phase(16'd1443, 16'd2, 16'd0, 90);

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d frames, %0d bytes, %0d units under %0d register settings",
             frames_sent, bytes_taken, units.units_checked, settings_used);
    $display("mismatches: %0d, units still expected: %0d",
             units.mismatch_count, units.pending());
    if (units.mismatch_count == 0 && units.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
